/* hdl/dfts_pkg.sv */
// dfts_pkg: constants, field widths and controller/datapath command and status
// types for the flush throttle scheduler. No dependencies.
`default_nettype none

package dfts_pkg;

  // Stream field widths
  localparam int unsigned ACT_W     = 2;
  localparam int unsigned TIME_W    = 32;
  localparam int unsigned FRAC_W    = 20;
  localparam int unsigned CNT32_W   = 32;
  localparam int unsigned ENT_W     = 31;
  localparam int unsigned SLEEP_W   = 30;
  localparam int unsigned QUANT_W   = 16;
  localparam int unsigned IN_DATA_W = 184;
  localparam int unsigned OUT_DATA_W = 64;
  localparam int unsigned CFG_IDX_W = 2;

  // Action codes carried in in_tuser
  localparam logic [ACT_W-1:0] ACT_L0_ACCESS = 2'd0;
  localparam logic [ACT_W-1:0] ACT_L1_ACCESS = 2'd1;
  localparam logic [ACT_W-1:0] ACT_EVALUATE  = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MANUAL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_L0_Q   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_L1_Q   = 2'd2;

  // Scheduling constants
  localparam int unsigned FRAC_SCALE     = 1000000;
  localparam int unsigned WINDOW_SECONDS = 60;
  localparam logic [TIME_W-1:0]  FRAC_LO   = TIME_W'(FRAC_SCALE * 5 / 10);
  localparam logic [TIME_W-1:0]  FRAC_HI   = TIME_W'(FRAC_SCALE * 9 / 10);
  localparam logic [TIME_W-1:0]  WINDOW    = TIME_W'(WINDOW_SECONDS);
  localparam logic [SLEEP_W-1:0] SLEEP_FOREVER = 30'd1000000000;
  localparam logic [SLEEP_W-1:0] QUOT_CAP      = 30'd100000;
  localparam logic [QUANT_W-1:0] QUANT_RESET   = 16'd120;

  // floor(x/10) = (x * RECIP_M) >> RECIP_SHIFT for any x below 2^34
  localparam int unsigned RECIP_X_W   = 34;
  localparam int unsigned RECIP_HALF  = 17;
  localparam int unsigned RECIP_SHIFT = 37;
  localparam logic [RECIP_X_W-1:0] RECIP_M = 34'd13743895348;

  // Divider: 63-bit dividend, 32-bit divisor
  localparam int unsigned DVD_W = 63;
  localparam int unsigned DVS_W = 32;

  typedef struct packed {
    logic load;    // latch accepted beat
    logic decide;  // apply access / simple evaluation rules
    logic tgt;     // reciprocal partial products for the 70% target
    logic sum;     // fold partial products, form flushed count
    logic diff;    // denominator and numerator
    logic check;   // sign checks, launch divide
    logic apply;   // take quotient
    logic emit;    // load result register
  } dfts_cmd_t;

  typedef struct packed {
    logic need_calc;  // mid-band evaluation with window elapsed
    logic go_div;     // divide required
    logic div_done;
    logic out_free;   // result register can take a beat
  } dfts_sts_t;

endpackage

`default_nettype wire

/* hdl/dfts_div.sv */
// dfts_div: restoring unsigned divider, one quotient bit per cycle.
// Depends on dfts_pkg.
`default_nettype none

module dfts_div (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  input  wire logic [dfts_pkg::DVD_W-1:0] dividend,
  input  wire logic [dfts_pkg::DVS_W-1:0] divisor,
  output logic                           done,
  output logic [dfts_pkg::DVD_W-1:0]      quotient
);
  import dfts_pkg::*;

  localparam int unsigned CNT_W = $clog2(DVD_W);

  logic [DVS_W-1:0] rem_r, rem_nxt;
  logic [DVD_W-1:0] quo_r, quo_nxt;
  logic [DVS_W-1:0] dvs_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r, done_r;
  logic [DVS_W:0]   trial;
  logic [DVS_W:0]   diff;

  // shift next dividend bit into the partial remainder, trial subtract
  always_comb begin
    trial = {rem_r, quo_r[DVD_W-1]};
    diff  = trial - {1'b0, dvs_r};
    if (!diff[DVS_W]) begin
      rem_nxt = diff[DVS_W-1:0];
      quo_nxt = {quo_r[DVD_W-2:0], 1'b1};
    end else begin
      rem_nxt = trial[DVS_W-1:0];
      quo_nxt = {quo_r[DVD_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(DVD_W - 1);
      end else if (busy_r) begin
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r - CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      dvs_r <= divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

`default_nettype wire

/* hdl/dfts_dp.sv */
// dfts_dp: datapath - item latch, schedule state, configuration registers,
// target/ratio arithmetic and result register. Depends on dfts_pkg, dfts_div.
`default_nettype none

module dfts_dp (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic [dfts_pkg::IN_DATA_W-1:0]      in_tdata,
  input  wire logic [dfts_pkg::ACT_W-1:0]          in_tuser,
  input  wire logic                                cfg_we,
  input  wire logic [dfts_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [dfts_pkg::QUANT_W-1:0]        cfg_wdata,
  input  wire dfts_pkg::dfts_cmd_t                 cmd,
  output dfts_pkg::dfts_sts_t                      sts,
  input  wire logic                                out_tready,
  output logic                                     out_tvalid,
  output logic [dfts_pkg::OUT_DATA_W-1:0]          out_tdata
);
  import dfts_pkg::*;

  // latched item
  logic [ACT_W-1:0]   act_r;
  logic [TIME_W-1:0]  now_r;
  logic [FRAC_W-1:0]  frac_r;
  logic [CNT32_W-1:0] wr_r, gr_r;
  logic [ENT_W-1:0]   dirty_r, size_r;

  // schedule state and configuration
  logic [TIME_W-1:0]  acc0_r, acc0_nxt, acc1_r, acc1_nxt, chg_r, chg_nxt;
  logic [SLEEP_W-1:0] flush_r, flush_nxt, summ_r, summ_nxt;
  logic               manual_r;
  logic [QUANT_W-1:0] q0_r, q1_r;

  // arithmetic pipeline
  logic [RECIP_X_W-1:0]            x7;
  logic [RECIP_X_W+RECIP_HALF-1:0] plo_r, phi_r;
  logic [RECIP_X_W+RECIP_X_W-1:0]  psum;
  logic [ENT_W-1:0]                target_r;
  logic [CNT32_W:0]                flushed_r;
  logic [SLEEP_W:0]                sleep1_r;
  logic [CNT32_W+1:0]              d_r;
  logic [DVD_W-1:0]                c_r;

  logic [DVD_W-1:0] quo;
  logic             div_done, div_start;
  logic             out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;

  logic is_eval, recent0, recent1, below_lo, above_hi, win_gone, d_pos;

  assign is_eval  = (act_r == ACT_EVALUATE);
  assign recent0  = (now_r - acc0_r) < {{(TIME_W-QUANT_W){1'b0}}, q0_r};
  assign recent1  = (now_r - acc1_r) < {{(TIME_W-QUANT_W){1'b0}}, q1_r};
  assign below_lo = {{(TIME_W-FRAC_W){1'b0}}, frac_r} < FRAC_LO;
  assign above_hi = {{(TIME_W-FRAC_W){1'b0}}, frac_r} > FRAC_HI;
  assign win_gone = (now_r - chg_r) > WINDOW;
  assign d_pos    = !d_r[CNT32_W+1] && (d_r != '0);

  assign div_start = cmd.check && d_pos && !flushed_r[CNT32_W];

  assign sts.need_calc = is_eval && !manual_r && recent0 && !below_lo && !above_hi
                         && win_gone;
  assign sts.go_div    = d_pos && !flushed_r[CNT32_W];
  assign sts.div_done  = div_done;
  assign sts.out_free  = !out_valid_r || out_tready;

  // state update
  always_comb begin
    acc0_nxt  = acc0_r;
    acc1_nxt  = acc1_r;
    chg_nxt   = chg_r;
    flush_nxt = flush_r;
    summ_nxt  = summ_r;
    if (cmd.decide) begin
      case (act_r)
        ACT_L0_ACCESS: acc0_nxt = now_r;
        ACT_L1_ACCESS: acc1_nxt = now_r;
        ACT_EVALUATE: begin
          if (manual_r) begin
            chg_nxt = now_r;
          end else if (recent0) begin
            summ_nxt = SLEEP_FOREVER;
            if (below_lo) begin
              flush_nxt = SLEEP_FOREVER;
              chg_nxt   = now_r;
            end else if (above_hi) begin
              flush_nxt = '0;
              chg_nxt   = now_r;
            end
          end else if (recent1) begin
            flush_nxt = '0;
            summ_nxt  = SLEEP_FOREVER;
          end else begin
            flush_nxt = '0;
            summ_nxt  = '0;
          end
        end
        default: ;
      endcase
    end
    if (cmd.check) begin
      if (!d_pos) begin
        flush_nxt = SLEEP_FOREVER;
      end else if (flushed_r[CNT32_W]) begin
        flush_nxt = '0;  // numerator negative: quotient saturates at zero
      end
    end
    if (cmd.apply) begin
      if (quo > {{(DVD_W-SLEEP_W){1'b0}}, QUOT_CAP}) flush_nxt = SLEEP_FOREVER;
      else flush_nxt = quo[SLEEP_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc0_r   <= '0;
      acc1_r   <= '0;
      chg_r    <= '0;
      flush_r  <= '0;
      summ_r   <= '0;
      manual_r <= 1'b0;
      q0_r     <= QUANT_RESET;
      q1_r     <= QUANT_RESET;
    end else begin
      acc0_r  <= acc0_nxt;
      acc1_r  <= acc1_nxt;
      chg_r   <= chg_nxt;
      flush_r <= flush_nxt;
      summ_r  <= summ_nxt;
      if (cfg_we) begin
        case (cfg_index)
          REG_MANUAL: manual_r <= cfg_wdata[0];
          REG_L0_Q:   q0_r     <= cfg_wdata;
          REG_L1_Q:   q1_r     <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  // item latch
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_r   <= in_tuser;
      now_r   <= in_tdata[31:0];
      frac_r  <= in_tdata[51:32];
      wr_r    <= in_tdata[83:52];
      gr_r    <= in_tdata[115:84];
      dirty_r <= in_tdata[146:116];
      size_r  <= in_tdata[177:147];
    end
  end

  // target = floor(7*size/10) via split reciprocal multiply
  assign x7   = {size_r, 3'b000} - {3'b000, size_r};
  assign psum = {{(RECIP_X_W-RECIP_HALF){1'b0}}, plo_r} + {phi_r, {RECIP_HALF{1'b0}}};

  always_ff @(posedge clk) begin
    if (cmd.tgt) begin
      plo_r <= {{(RECIP_X_W){1'b0}}, x7[RECIP_HALF-1:0]}
               * {{RECIP_HALF{1'b0}}, RECIP_M};
      phi_r <= {{(RECIP_X_W){1'b0}}, x7[RECIP_X_W-1:RECIP_HALF]}
               * {{RECIP_HALF{1'b0}}, RECIP_M};
    end
    if (cmd.sum) begin
      target_r  <= psum[RECIP_SHIFT +: ENT_W];
      flushed_r <= {wr_r[CNT32_W-1], wr_r} - {gr_r[CNT32_W-1], gr_r};
      sleep1_r  <= {1'b0, flush_r} + {{SLEEP_W{1'b0}}, 1'b1};
    end
    if (cmd.diff) begin
      d_r <= {{2{wr_r[CNT32_W-1]}}, wr_r} + {3'b000, dirty_r} - {3'b000, target_r};
      c_r <= {{SLEEP_W{1'b0}}, flushed_r[CNT32_W-1:0]}
             * {{CNT32_W{1'b0}}, sleep1_r};
    end
  end

  dfts_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (c_r),
    .divisor  (d_r[DVS_W-1:0]),
    .done     (div_done),
    .quotient (quo)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_data_r <= {{(OUT_DATA_W-2*SLEEP_W){1'b0}}, summ_r, flush_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

`default_nettype wire

/* hdl/dfts_ctrl.sv */
// dfts_ctrl: sequencing state machine for the flush throttle scheduler.
// Depends on dfts_pkg; drives dfts_dp through command/status structs.
`default_nettype none

module dfts_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_tvalid,
  output logic                     in_tready,
  input  wire dfts_pkg::dfts_sts_t sts,
  output dfts_pkg::dfts_cmd_t      cmd
);
  import dfts_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECIDE = 3'd1;
  localparam logic [2:0] S_TGT    = 3'd2;
  localparam logic [2:0] S_SUM    = 3'd3;
  localparam logic [2:0] S_DIFF   = 3'd4;
  localparam logic [2:0] S_CHK    = 3'd5;
  localparam logic [2:0] S_DIV    = 3'd6;
  localparam logic [2:0] S_EMIT   = 3'd7;

  logic [2:0] state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      S_IDLE: begin
        // no beat is taken while reset is held
        in_tready = rst_n;
        if (in_tvalid && rst_n) begin
          cmd.load  = 1'b1;
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        cmd.decide = 1'b1;
        state_nxt  = sts.need_calc ? S_TGT : S_EMIT;
      end
      S_TGT: begin
        cmd.tgt   = 1'b1;
        state_nxt = S_SUM;
      end
      S_SUM: begin
        cmd.sum   = 1'b1;
        state_nxt = S_DIFF;
      end
      S_DIFF: begin
        cmd.diff  = 1'b1;
        state_nxt = S_CHK;
      end
      S_CHK: begin
        cmd.check = 1'b1;
        state_nxt = sts.go_div ? S_DIV : S_EMIT;
      end
      S_DIV: begin
        if (sts.div_done) begin
          cmd.apply = 1'b1;
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

/* hdl/disk_flush_throttle_scheduler.sv */
// disk_flush_throttle_scheduler: top level, joins controller and datapath.
// Depends on dfts_pkg, dfts_ctrl, dfts_dp (which holds dfts_div).
//
//  channel | direction | beat contents
//  --------+-----------+-----------------------------------------------------
//  in_     | slave     | tuser: action; tdata: time, fraction, counters, sizes
//  out_    | master    | tdata: flush sleep, summing sleep
//  cfg_    | write     | index 0 manual mode, 1 level-0 quantum, 2 level-1 quantum
//
// One item in flight. Access beats and simply settled evaluations go from accept
// through decide to emit; ratio evaluations pass the target, sum, difference and
// sign-check steps and emit there or after a divide (63 steps of the bit-serial
// 63/32 divider). The next beat is taken once the block is back in idle, while the
// result may still wait. A stalled out_tready holds the block in its emit step.
// Reset is synchronous, active low; quanta return to 120 s, schedule state and manual mode to 0.
`default_nettype none

module disk_flush_throttle_scheduler (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  // [31:0] now_seconds, [51:32] dirty_fraction, [83:52] writes_in_window,
  // [115:84] dirty_growth_in_window, [146:116] dirty_entries,
  // [177:147] cache_entries, [183:178] zero
  input  wire logic [dfts_pkg::IN_DATA_W-1:0]     in_tdata,
  // [1:0] action
  input  wire logic [dfts_pkg::ACT_W-1:0]         in_tuser,
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  // [29:0] flush_sleep, [59:30] summing_sleep, [63:60] zero
  output logic [dfts_pkg::OUT_DATA_W-1:0]         out_tdata,
  input  wire logic                               cfg_we,
  input  wire logic [dfts_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [dfts_pkg::QUANT_W-1:0]       cfg_wdata
);
  import dfts_pkg::*;

  dfts_cmd_t cmd;
  dfts_sts_t sts;

  // sequencing only; no payload passes through the controller
  dfts_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // state, arithmetic, divider and result register
  dfts_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .cmd        (cmd),
    .sts        (sts),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata)
  );

endmodule

`default_nettype wire

/* hdl/dfts_chk.sv */
// dfts_chk: port-level checks for the flush throttle scheduler, bound to the
// top level. Depends on dfts_pkg and disk_flush_throttle_scheduler.
`default_nettype none

module dfts_chk (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_tvalid,
  input  wire logic                               in_tready,
  input  wire logic                               out_tvalid,
  input  wire logic                               out_tready,
  input  wire logic [dfts_pkg::OUT_DATA_W-1:0]    out_tdata
);
  import dfts_pkg::*;

  // a stalled result beat stays up
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result beat dropped while stalled");

  // one item at a time: no accept directly after an accept
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second beat accepted while busy");

  // summing sleep is either zero or forever
  a_summ_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[59:30] == '0) || (out_tdata[59:30] == SLEEP_FOREVER))
    else $error("summing sleep out of set");

  // flush sleep is capped or forever
  a_flush_cap: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[29:0] <= QUOT_CAP) || (out_tdata[29:0] == SLEEP_FOREVER))
    else $error("flush sleep above cap");

endmodule

bind disk_flush_throttle_scheduler dfts_chk u_dfts_chk (.*);

`default_nettype wire
